// ===== hdl/bb3_pkg.sv =====
// Shared types and constants for the 3x3 toroidal box blur.
// Used by the front, back and top-level modules; no dependencies.
package bb3_pkg;

    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] REG_WIDTH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic   last;
        pixel_t pix;
    } result_t;

endpackage

// ===== hdl/bb3_front.sv =====
// Front end: accepts beats, handles config, writes the frame memory on loads
// and queues emit commands. Depends on bb3_pkg.
module bb3_front
    import bb3_pkg::*;
#(
    parameter int MaxW = 256,
    parameter int MaxH = 256,
    parameter int CW = $clog2(MaxW + 1),
    parameter int RW = $clog2(MaxH + 1),
    parameter int CA = $clog2(MaxW),
    parameter int RA = $clog2(MaxH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             opcode,
    input  logic [7:0]       in_blue,
    input  logic [7:0]       in_green,
    input  logic [7:0]       in_red,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [8:0]       cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output logic [CW-1:0]    w_eff,
    output logic [RW-1:0]    h_eff,
    output logic             restart,
    input  logic             frame_done,
    output logic             wr_en,
    output logic [CA-1:0]    wr_col,
    output logic [RA-1:0]    wr_row,
    output pixel_t           wr_pix
);

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [CW-1:0] lcol_reg;
    logic [CW-1:0] lcol_next;
    logic [RW-1:0] lrow_reg;
    logic [RW-1:0] lrow_next;
    logic full_reg;
    logic full_next;
    logic [CW-1:0] emits_col_reg;
    logic [RW-1:0] emits_row_reg;
    logic acc;
    logic load_go;
    logic emit_go;
    logic last_queued;

    function automatic logic [15:0] clampd(input logic [8:0] v, input int mx);
        logic [15:0] r;
        begin
            r = 16'(v);
            if (v == 9'd0)
            begin
                r = 16'd1;
            end
            else if (32'(v) > mx)
            begin
                r = 16'(mx);
            end
            return r;
        end
    endfunction

    assign w_eff = CW'(clampd(width_reg, MaxW));
    assign h_eff = RW'(clampd(height_reg, MaxH));
    assign cfg_ready = 1'b1;
    assign restart = cfg_valid;

    // Once every emit of the frame is queued, all further beats wait for frame_done, so a
    // load for the next frame is not taken as a load into the frame being emitted.
    assign last_queued = (emits_row_reg == h_eff);
    assign in_stall = cfg_valid
                      || (full_reg && (last_queued || (opcode == OP_EMIT && q_full)));
    assign acc = in_valid && !in_stall;
    assign load_go = acc && opcode == OP_LOAD && !full_reg;
    assign emit_go = acc && opcode == OP_EMIT && full_reg;
    assign q_push = emit_go;

    assign wr_en = load_go;
    assign wr_col = lcol_reg[CA-1:0];
    assign wr_row = lrow_reg[RA-1:0];
    assign wr_pix = '{red: in_red, green: in_green, blue: in_blue};

    always_comb
    begin
        lcol_next = lcol_reg;
        lrow_next = lrow_reg;
        full_next = full_reg;
        if (load_go)
        begin
            lcol_next = lcol_reg + CW'(1);
            if (lcol_next >= w_eff)
            begin
                lcol_next = '0;
                lrow_next = lrow_reg + RW'(1);
                if (lrow_next >= h_eff)
                begin
                    lrow_next = '0;
                    full_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 9'd256;
            height_reg <= 9'd256;
            lcol_reg <= '0;
            lrow_reg <= '0;
            full_reg <= 1'b0;
            emits_col_reg <= '0;
            emits_row_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            lcol_reg <= '0;
            lrow_reg <= '0;
            full_reg <= 1'b0;
            emits_col_reg <= '0;
            emits_row_reg <= '0;
        end
        else if (frame_done)
        begin
            full_reg <= 1'b0;
            emits_col_reg <= '0;
            emits_row_reg <= '0;
        end
        else
        begin
            lcol_reg <= lcol_next;
            lrow_reg <= lrow_next;
            full_reg <= full_next;
            if (emit_go)
            begin
                if (emits_col_reg + CW'(1) >= w_eff)
                begin
                    emits_col_reg <= '0;
                    emits_row_reg <= emits_row_reg + RW'(1);
                end
                else
                begin
                    emits_col_reg <= emits_col_reg + CW'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/bb3_back.sv =====
// Back end: pops emit commands, reads nine neighbors from the frame memory,
// sums and divides by nine, and holds the result. Depends on bb3_pkg.
module bb3_back
    import bb3_pkg::*;
#(
    parameter int MaxW = 256,
    parameter int MaxH = 256,
    parameter int CW = $clog2(MaxW + 1),
    parameter int RW = $clog2(MaxH + 1),
    parameter int CA = $clog2(MaxW),
    parameter int RA = $clog2(MaxH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  logic [CW-1:0] w_eff,
    input  logic [RW-1:0] h_eff,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          frame_done,
    input  logic          wr_en,
    input  logic [CA-1:0] wr_col,
    input  logic [RA-1:0] wr_row,
    input  pixel_t        wr_pix,
    output logic          out_valid,
    input  logic          out_stall,
    output result_t       result
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    localparam int AW = CA + RA;

    pixel_t mem [2**AW];
    state_t state_reg;
    state_t state_next;
    logic [CW-1:0] ecol_reg;
    logic [RW-1:0] erow_reg;
    logic [3:0] cnt_reg;
    logic rd_valid_reg;
    pixel_t rd_reg;
    logic [11:0] sum_r_reg;
    logic [11:0] sum_g_reg;
    logic [11:0] sum_b_reg;
    result_t res_reg;
    logic [1:0] di;
    logic [1:0] dj;
    logic [RW-1:0] rr;
    logic [CW-1:0] cc;
    logic [AW-1:0] rd_addr;
    logic last_w;

    function automatic logic [7:0] div9(input logic [11:0] s);
        logic [23:0] p;
        begin
            p = (24'(s) + 24'd4) * 24'd3641;
            return p[22:15];
        end
    endfunction

    assign di = (cnt_reg < 4'd3) ? 2'd0 : (cnt_reg < 4'd6) ? 2'd1 : 2'd2;
    assign dj = 2'(cnt_reg - 4'(di) * 4'd3);

    always_comb
    begin
        case (di)
            2'd0: rr = (erow_reg == '0) ? h_eff - RW'(1) : erow_reg - RW'(1);
            2'd2: rr = (erow_reg + RW'(1) >= h_eff) ? '0 : erow_reg + RW'(1);
            default: rr = erow_reg;
        endcase
        case (dj)
            2'd0: cc = (ecol_reg == '0) ? w_eff - CW'(1) : ecol_reg - CW'(1);
            2'd2: cc = (ecol_reg + CW'(1) >= w_eff) ? '0 : ecol_reg + CW'(1);
            default: cc = ecol_reg;
        endcase
    end

    assign rd_addr = {rr[RA-1:0], cc[CA-1:0]};
    assign last_w = (erow_reg + RW'(1) >= h_eff) && (ecol_reg + CW'(1) >= w_eff);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_row, wr_col}] <= wr_pix;
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!q_empty) state_next = S_READ;
            S_READ: if (cnt_reg == 4'd9) state_next = S_DIV;
            S_DIV: state_next = S_OUT;
            S_OUT: if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty && !restart;
    assign out_valid = (state_reg == S_OUT);
    assign result = res_reg;
    assign frame_done = (state_reg == S_OUT) && !out_stall && res_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ecol_reg <= '0;
            erow_reg <= '0;
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            state_reg <= S_IDLE;
            ecol_reg <= '0;
            erow_reg <= '0;
            cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= (state_reg == S_READ) && cnt_reg < 4'd9;
            if (state_reg == S_IDLE)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_READ)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            if (state_reg == S_OUT && !out_stall)
            begin
                if (res_reg.last)
                begin
                    ecol_reg <= '0;
                    erow_reg <= '0;
                end
                else if (ecol_reg + CW'(1) >= w_eff)
                begin
                    ecol_reg <= '0;
                    erow_reg <= erow_reg + RW'(1);
                end
                else
                begin
                    ecol_reg <= ecol_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            sum_r_reg <= sum_r_reg + 12'(rd_reg.red);
            sum_g_reg <= sum_g_reg + 12'(rd_reg.green);
            sum_b_reg <= sum_b_reg + 12'(rd_reg.blue);
        end
        if (state_reg == S_DIV)
        begin
            res_reg.pix.red <= div9(sum_r_reg);
            res_reg.pix.green <= div9(sum_g_reg);
            res_reg.pix.blue <= div9(sum_b_reg);
            res_reg.last <= last_w;
        end
    end

endmodule

// ===== hdl/bb3_queue.sv =====
// Small command queue between front and back; counts pending emit commands.
// No dependencies.
module bb3_queue
#(
    parameter int Depth = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic flush,
    input  logic push,
    input  logic pop,
    output logic full,
    output logic empty
);

    logic [$clog2(Depth+1)-1:0] cnt_reg;

    assign full = (cnt_reg == ($clog2(Depth+1))'(Depth));
    assign empty = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (flush)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + (($clog2(Depth+1))'(push)) - (($clog2(Depth+1))'(pop));
        end
    end

endmodule

// ===== hdl/box_blur_3x3_wraparound_top.sv =====
// In the back end an emit beat pops the command queue, makes nine reads through the single
// frame-memory read port, drains the registered read, then passes one divide stage and one
// output stage, where it waits out any output stall. Up to two emit beats wait in the queue;
// once every emit of the frame is queued, further beats stall until the last pixel of the
// frame has been taken.
// Top level of the 3x3 toroidal box blur; instantiates bb3_front, bb3_queue, bb3_back.
module box_blur_3x3_wraparound_top
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_green,
    input  logic [7:0] in_red,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red,
    output logic       last_pixel,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int CA = $clog2(MAX_WIDTH);
    localparam int RA = $clog2(MAX_HEIGHT);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic restart;
    logic frame_done;
    logic wr_en;
    logic [CA-1:0] wr_col;
    logic [RA-1:0] wr_row;
    pixel_t wr_pix;
    result_t result;

    bb3_front #(
        .MaxW(MAX_WIDTH), .MaxH(MAX_HEIGHT), .CW(CW), .RW(RW), .CA(CA), .RA(RA)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .q_full(q_full), .q_push(q_push), .w_eff(w_eff),
        .h_eff(h_eff), .restart(restart), .frame_done(frame_done), .wr_en(wr_en),
        .wr_col(wr_col), .wr_row(wr_row), .wr_pix(wr_pix)
    );

    bb3_queue #(.Depth(2)) u_queue (
        .clk(clk), .rst_n(rst_n), .flush(restart), .push(q_push), .pop(q_pop),
        .full(q_full), .empty(q_empty)
    );

    bb3_back #(
        .MaxW(MAX_WIDTH), .MaxH(MAX_HEIGHT), .CW(CW), .RW(RW), .CA(CA), .RA(RA)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .restart(restart), .w_eff(w_eff), .h_eff(h_eff),
        .q_empty(q_empty), .q_pop(q_pop), .frame_done(frame_done), .wr_en(wr_en),
        .wr_col(wr_col), .wr_row(wr_row), .wr_pix(wr_pix), .out_valid(out_valid),
        .out_stall(out_stall), .result(result)
    );

    assign out_blue = result.pix.blue;
    assign out_green = result.pix.green;
    assign out_red = result.pix.red;
    assign last_pixel = result.last;

endmodule
